### rtl/core/assert_macros.svh
// Assertion helpers for the RTL. Both forms take a label, a clock,
// an active-low reset, a property expression and a message string.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define QDC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define QDC_ASSERT_NEVER(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error(msg);
`else
`define QDC_ASSERT(lbl, clk, rstn, prop, msg)
`define QDC_ASSERT_NEVER(lbl, clk, rstn, prop, msg)
`endif

`endif

### rtl/core/qdc_pkg.sv
`timescale 1ns / 1ps

package qdc_pkg;

  // Width of the position value and of the clamp bounds.
  localparam int unsigned POS_W   = 16;
  localparam int unsigned TALLY_W = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VALUE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS      = 2'd2;

  localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

  // Current configuration as seen by the datapath.
  typedef struct packed {
    logic [POS_W-1:0]   min_value;
    logic [POS_W-1:0]   max_value;
    logic [TALLY_W-1:0] steps_per_detent;
  } cfg_t;

  // One registered pin sample.
  typedef struct packed {
    logic       valid;
    logic [1:0] phase;
  } sample_t;

  // Next phase in the forward direction: 0 -> 2 -> 3 -> 1 -> 0.
  function automatic logic [1:0] next_forward(input logic [1:0] ph);
    logic [1:0] nxt;
    unique case (ph)
      2'd0:    nxt = 2'd2;
      2'd1:    nxt = 2'd0;
      2'd2:    nxt = 2'd3;
      2'd3:    nxt = 2'd1;
      default: nxt = 2'd0;
    endcase
    return nxt;
  endfunction

endpackage

### rtl/core/qdc_cfg_regs.sv
`timescale 1ns / 1ps

module qdc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [qdc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qdc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output qdc_pkg::cfg_t                    cfg
);

  logic [qdc_pkg::POS_W-1:0]   min_value_r;
  logic [qdc_pkg::POS_W-1:0]   max_value_r;
  logic [qdc_pkg::TALLY_W-1:0] steps_r;

  // Writes are always taken; the user must issue them only while idle, which the block does not enforce.
  assign cfg_ready = 1'b1;

  // Register file, one write transaction per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_value_r <= '0;
      max_value_r <= {qdc_pkg::POS_W{1'b1}};
      steps_r     <= qdc_pkg::TALLY_W'(4);
    end else if (cfg_valid) begin
      if (cfg_index == qdc_pkg::REG_MIN_VALUE) begin
        min_value_r <= qdc_pkg::POS_W'(cfg_data);
      end
      if (cfg_index == qdc_pkg::REG_MAX_VALUE) begin
        max_value_r <= qdc_pkg::POS_W'(cfg_data);
      end
      if (cfg_index == qdc_pkg::REG_STEPS) begin
        steps_r <= cfg_data[qdc_pkg::TALLY_W-1:0];
      end
    end
  end

  assign cfg.min_value        = min_value_r;
  assign cfg.max_value        = max_value_r;
  assign cfg.steps_per_detent = steps_r;

endmodule

### rtl/core/qdc_in_reg.sv
`timescale 1ns / 1ps

module qdc_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [1:0]        in_phase,
  input  logic              advance,
  output qdc_pkg::sample_t  sample
);

  logic       valid_r;
  logic [1:0] phase_r;

  // The register is free when empty or when its sample moves on this cycle.
  assign in_tready = !valid_r || advance;

  // Control bit of the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  // Sample payload, loaded on each accepted transaction.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      phase_r <= in_phase;
    end
  end

  assign sample.valid = valid_r;
  assign sample.phase = phase_r;

endmodule

### rtl/core/qdc_engine.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module qdc_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  qdc_pkg::sample_t            sample,
  input  qdc_pkg::cfg_t               cfg,
  output logic                        advance,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [qdc_pkg::POS_W-1:0]   position
);

  logic [1:0]                  last_phase_r, last_phase_nxt;
  logic [qdc_pkg::TALLY_W-1:0] fwd_tally_r, fwd_tally_nxt;
  logic [qdc_pkg::TALLY_W-1:0] bwd_tally_r, bwd_tally_nxt;
  logic [qdc_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic                        out_valid_r;

  logic                        take;
  logic                        phase_chg;
  logic                        is_fwd, is_bwd;
  logic [qdc_pkg::TALLY_W-1:0] steps_eff;
  logic [qdc_pkg::TALLY_W-1:0] fwd_bump, bwd_bump;
  logic [qdc_pkg::POS_W-1:0]   pos_mid;

  // The result register moves when empty or when its transaction completes.
  assign advance = !out_valid_r || out_tready;
  assign take    = advance && sample.valid;

  assign phase_chg = sample.phase != last_phase_r;
  assign is_fwd    = sample.phase == qdc_pkg::next_forward(last_phase_r);
  assign is_bwd    = last_phase_r == qdc_pkg::next_forward(sample.phase);
  assign steps_eff = (cfg.steps_per_detent == '0) ? qdc_pkg::TALLY_W'(1)
                                                  : cfg.steps_per_detent;

  // Saturating tally increments.
  assign fwd_bump = (fwd_tally_r == qdc_pkg::TALLY_MAX) ? fwd_tally_r
                                                        : fwd_tally_r + 1'b1;
  assign bwd_bump = (bwd_tally_r == qdc_pkg::TALLY_MAX) ? bwd_tally_r
                                                        : bwd_tally_r + 1'b1;

  // Next state for one sample: count, then check forward before backward.
  always_comb begin
    last_phase_nxt = last_phase_r;
    fwd_tally_nxt  = fwd_tally_r;
    bwd_tally_nxt  = bwd_tally_r;
    pos_mid        = pos_r;
    pos_nxt        = pos_r;
    if (phase_chg) begin
      last_phase_nxt = sample.phase;
      if (is_fwd) begin
        fwd_tally_nxt = fwd_bump;
      end else if (is_bwd) begin
        bwd_tally_nxt = bwd_bump;
      end

      if (fwd_tally_nxt >= steps_eff) begin
        pos_mid       = (pos_r >= cfg.max_value) ? cfg.max_value : pos_r + 1'b1;
        fwd_tally_nxt = '0;
      end
      pos_nxt = pos_mid;

      if (bwd_tally_nxt >= steps_eff) begin
        pos_nxt       = (pos_mid <= cfg.min_value) ? cfg.min_value
                                                   : pos_mid - 1'b1;
        bwd_tally_nxt = '0;
      end
    end
  end

  // Decoder state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_phase_r <= '0;
      fwd_tally_r  <= '0;
      bwd_tally_r  <= '0;
      pos_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= sample.valid;
      end
      if (take) begin
        last_phase_r <= last_phase_nxt;
        fwd_tally_r  <= fwd_tally_nxt;
        bwd_tally_r  <= bwd_tally_nxt;
        pos_r        <= pos_nxt;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign position   = pos_r;

  // A sample with an unchanged phase leaves the position alone.
  `QDC_ASSERT(a_hold_pos, clk, rst_n, (take && !phase_chg) |=> $stable(pos_r), "position moved on unchanged phase")
  // After a phase change both tallies sit below the detent size.
  `QDC_ASSERT(a_fwd_below, clk, rst_n, (take && phase_chg) |=> (fwd_tally_r < $past(steps_eff)), "forward tally left at or above detent")
  `QDC_ASSERT(a_bwd_below, clk, rst_n, (take && phase_chg) |=> (bwd_tally_r < $past(steps_eff)), "backward tally left at or above detent")
  // A result appears only for a sample that was waiting in the input register.
  `QDC_ASSERT(a_out_source, clk, rst_n, $rose(out_valid_r) |-> $past(sample.valid), "result without a sample")

endmodule

### rtl/core/quadrature_detent_counter_top.sv
`timescale 1ns / 1ps

// Quadrature detent counter.
// Input stream: one transaction per sample of the encoder pins, in_tdata[0]
// is channel A and in_tdata[1] is channel B. Every sample yields exactly one
// result transaction carrying the clamped position after that sample.
// Configuration writes (min_value, max_value, steps_per_detent at indexes 0,
// 1 and 2) are taken in any cycle and must only be issued while idle.
// An accepted sample is held in the input register, and the decode and
// clamp logic loads the result register from it. Throughput is one sample
// per cycle while the receiver does not stall; the single step of tally and
// position update between those registers sets the rate.
// When the receiver stalls, the result register holds its transaction. An
// empty input register still takes one more sample; a full one drops
// in_tready in the same cycle as out_tready.
// Synchronous reset clears both valid bits, the tallies, the last phase and
// the position, and restores the configuration to 0, 65535 and 4.
module quadrature_detent_counter_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [0] pin_a, [1] pin_b
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [15:0]                         out_tdata,  // [15:0] position
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [qdc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qdc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  qdc_pkg::cfg_t              cfg;
  qdc_pkg::sample_t           sample;
  logic                       advance;
  logic [qdc_pkg::POS_W-1:0]  position;

  qdc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  qdc_in_reg u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_phase  (in_tdata[1:0]),
    .advance   (advance),
    .sample    (sample)
  );

  qdc_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .sample     (sample),
    .cfg        (cfg),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .position   (position)
  );

  assign out_tdata = 16'(position);

endmodule
